// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared request, response and pipeline stage types, and the fixed constants
// of the six-sector conversion.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Input limits.
   localparam logic [8:0] HUE_TURN   = 9'd360;
   localparam logic [6:0] PCT_FULL   = 7'd100;

   // Sector boundaries in degrees.
   localparam logic [8:0] SECTOR_DEG = 9'd60;
   localparam logic [8:0] HUE_BASE_1 = 9'd60;
   localparam logic [8:0] HUE_BASE_2 = 9'd120;
   localparam logic [8:0] HUE_BASE_3 = 9'd180;
   localparam logic [8:0] HUE_BASE_4 = 9'd240;
   localparam logic [8:0] HUE_BASE_5 = 9'd300;

   // Sector codes.
   localparam logic [2:0] SEC_R_TO_Y = 3'd0;
   localparam logic [2:0] SEC_Y_TO_G = 3'd1;
   localparam logic [2:0] SEC_G_TO_C = 3'd2;
   localparam logic [2:0] SEC_C_TO_B = 3'd3;
   localparam logic [2:0] SEC_B_TO_M = 3'd4;
   localparam logic [2:0] SEC_M_TO_R = 3'd5;

   // Colour numerators are held over 600000 = 6000 * 100.
   localparam logic [12:0] NUM_UNIT   = 13'd6000;
   localparam logic [5:0]  FRAC_FULL  = 6'd60;

   // floor(255 * n / 600000) = floor(floor(17 * n / 64) / 625).
   // The division by 625 is a multiply by ceil(2^27 / 625) and a shift,
   // which is exact for every dividend below 2^18.
   localparam int          PRE_SHIFT   = 6;
   localparam logic [17:0] RECIP_MULT  = 18'd214749;
   localparam int          RECIP_SHIFT = 27;

   typedef struct packed {
      logic [8:0] hue_deg;
      logic [6:0] sat_pct;
      logic [6:0] val_pct;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // After decode: sector, fraction in degrees and clamped percentages.
   typedef struct packed {
      logic       valid;
      logic [2:0] sector;
      logic [5:0] frac;
      logic [6:0] sat;
      logic [6:0] val;
   } dec_stage_type;

   // Colour numerators over the common denominator 600000.
   typedef struct packed {
      logic        valid;
      logic [2:0]  sector;
      logic [19:0] vn;
      logic [19:0] pn;
      logic [19:0] qn;
      logic [19:0] tn;
   } num_stage_type;

endpackage

// ===== rtl/hsv2rgb_decode.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB hue decode
// Folds the hue into one turn, clamps saturation and value, and splits the
// hue into a sector and an offset within the sector. One register stage.
// ----------------------------------------------------------------------------
module hsv2rgb_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  hsv2rgb_pkg::req_type       in_data,
   output hsv2rgb_pkg::dec_stage_type out_stage
);

   hsv2rgb_pkg::dec_stage_type stage_ff;
   hsv2rgb_pkg::dec_stage_type stage_in;
   logic [8:0] hue;
   logic [8:0] base;
   logic [8:0] offset;

   always_comb begin
      hue = in_data.hue_deg;
      if (in_data.hue_deg >= hsv2rgb_pkg::HUE_TURN) begin
         hue = in_data.hue_deg - hsv2rgb_pkg::HUE_TURN;
      end

      if (hue >= hsv2rgb_pkg::HUE_BASE_5) begin
         stage_in.sector = hsv2rgb_pkg::SEC_M_TO_R;
         base            = hsv2rgb_pkg::HUE_BASE_5;
      end else if (hue >= hsv2rgb_pkg::HUE_BASE_4) begin
         stage_in.sector = hsv2rgb_pkg::SEC_B_TO_M;
         base            = hsv2rgb_pkg::HUE_BASE_4;
      end else if (hue >= hsv2rgb_pkg::HUE_BASE_3) begin
         stage_in.sector = hsv2rgb_pkg::SEC_C_TO_B;
         base            = hsv2rgb_pkg::HUE_BASE_3;
      end else if (hue >= hsv2rgb_pkg::HUE_BASE_2) begin
         stage_in.sector = hsv2rgb_pkg::SEC_G_TO_C;
         base            = hsv2rgb_pkg::HUE_BASE_2;
      end else if (hue >= hsv2rgb_pkg::HUE_BASE_1) begin
         stage_in.sector = hsv2rgb_pkg::SEC_Y_TO_G;
         base            = hsv2rgb_pkg::HUE_BASE_1;
      end else begin
         stage_in.sector = hsv2rgb_pkg::SEC_R_TO_Y;
         base            = 9'd0;
      end

      // The offset is always below 60, so six bits hold it.
      offset         = hue - base;
      stage_in.frac  = offset[5:0];
      stage_in.valid = in_valid;
      stage_in.sat   = (in_data.sat_pct > hsv2rgb_pkg::PCT_FULL) ?
                       hsv2rgb_pkg::PCT_FULL : in_data.sat_pct;
      stage_in.val   = (in_data.val_pct > hsv2rgb_pkg::PCT_FULL) ?
                       hsv2rgb_pkg::PCT_FULL : in_data.val_pct;
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign out_stage = stage_ff;

endmodule

// ===== rtl/hsv2rgb_mix.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB numerator stages
// Forms the p, q and t terms over the common denominator 600000: first the
// saturation products, then the products with value. Two register stages.
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
   input  logic                       clock,
   input  logic                       reset,
   input  hsv2rgb_pkg::dec_stage_type in_stage,
   output hsv2rgb_pkg::num_stage_type out_stage
);

   // First stage: terms that depend on saturation only.
   logic        sat_valid_ff;
   logic [2:0]  sat_sector_ff;
   logic [6:0]  sat_val_ff;
   logic [12:0] sat_a_ff;
   logic [12:0] sat_b_ff;
   logic [12:0] sat_c_ff;
   logic [12:0] sat_a_in;
   logic [12:0] sat_b_in;
   logic [12:0] sat_c_in;
   logic [5:0]  frac_rest;
   logic [6:0]  sat_rest;

   hsv2rgb_pkg::num_stage_type num_ff;
   hsv2rgb_pkg::num_stage_type num_in;

   always_comb begin
      frac_rest = hsv2rgb_pkg::FRAC_FULL - in_stage.frac;
      sat_rest  = hsv2rgb_pkg::PCT_FULL - in_stage.sat;
      // 6000 - f*s, 6000 - (60-f)*s and 60*(100-s), all within 0..6000.
      sat_a_in  = hsv2rgb_pkg::NUM_UNIT - {7'd0, in_stage.frac} * {6'd0, in_stage.sat};
      sat_b_in  = hsv2rgb_pkg::NUM_UNIT - {7'd0, frac_rest} * {6'd0, in_stage.sat};
      sat_c_in  = {7'd0, hsv2rgb_pkg::FRAC_FULL} * {6'd0, sat_rest};
   end

   always_ff @(posedge clock) begin
      sat_sector_ff <= in_stage.sector;
      sat_val_ff    <= in_stage.val;
      sat_a_ff      <= sat_a_in;
      sat_b_ff      <= sat_b_in;
      sat_c_ff      <= sat_c_in;
      if (reset) begin
         sat_valid_ff <= 1'b0;
      end else begin
         sat_valid_ff <= in_stage.valid;
      end
   end

   // Second stage: scale every term by value.
   always_comb begin
      num_in.valid  = sat_valid_ff;
      num_in.sector = sat_sector_ff;
      num_in.vn     = {13'd0, sat_val_ff} * {7'd0, hsv2rgb_pkg::NUM_UNIT};
      num_in.pn     = {13'd0, sat_val_ff} * {7'd0, sat_c_ff};
      num_in.qn     = {13'd0, sat_val_ff} * {7'd0, sat_a_ff};
      num_in.tn     = {13'd0, sat_val_ff} * {7'd0, sat_b_ff};
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      if (reset) begin
         num_ff.valid <= 1'b0;
      end
   end

   assign out_stage = num_ff;

endmodule

// ===== rtl/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel scaling
// Routes the numerators to the channels by sector and takes
// floor(255 * n / 600000) for each. Two register stages.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
   input  logic                       clock,
   input  logic                       reset,
   input  hsv2rgb_pkg::num_stage_type in_stage,
   output logic                       out_valid,
   output hsv2rgb_pkg::rsp_type       out_data
);

   localparam int LANES = 3;

   logic [19:0] num  [LANES];
   logic [23:0] wide [LANES];
   logic [17:0] part_in [LANES];
   logic [17:0] part_ff [LANES];
   logic        part_valid_ff;
   logic [35:0] prod [LANES];
   logic [7:0]  chan [LANES];

   hsv2rgb_pkg::rsp_type rsp_ff;
   hsv2rgb_pkg::rsp_type rsp_in;
   logic                 rsp_valid_ff;

   always_comb begin
      case (in_stage.sector)
         hsv2rgb_pkg::SEC_R_TO_Y: begin
            num[0] = in_stage.vn; num[1] = in_stage.tn; num[2] = in_stage.pn;
         end
         hsv2rgb_pkg::SEC_Y_TO_G: begin
            num[0] = in_stage.qn; num[1] = in_stage.vn; num[2] = in_stage.pn;
         end
         hsv2rgb_pkg::SEC_G_TO_C: begin
            num[0] = in_stage.pn; num[1] = in_stage.vn; num[2] = in_stage.tn;
         end
         hsv2rgb_pkg::SEC_C_TO_B: begin
            num[0] = in_stage.pn; num[1] = in_stage.qn; num[2] = in_stage.vn;
         end
         hsv2rgb_pkg::SEC_B_TO_M: begin
            num[0] = in_stage.tn; num[1] = in_stage.pn; num[2] = in_stage.vn;
         end
         default: begin
            num[0] = in_stage.vn; num[1] = in_stage.pn; num[2] = in_stage.qn;
         end
      endcase

      for (int i = 0; i < LANES; i++) begin
         // 17 * n by shift and add, then the power-of-two part of 40000.
         wide[i]    = {num[i], 4'd0} + {4'd0, num[i]};
         part_in[i] = wide[i][23:hsv2rgb_pkg::PRE_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      if (reset) begin
         part_valid_ff <= 1'b0;
      end else begin
         part_valid_ff <= in_stage.valid;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod[i] = {18'd0, part_ff[i]} * {18'd0, hsv2rgb_pkg::RECIP_MULT};
         chan[i] = prod[i][hsv2rgb_pkg::RECIP_SHIFT +: 8];
      end
      rsp_in.red   = chan[0];
      rsp_in.green = chan[1];
      rsp_in.blue  = chan[2];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= part_valid_ff;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// A request taken at a clock edge passes all the stage registers below, then
// shows its result on rsp_data, with rsp_strobe high, for one cycle.
// Throughput: one request per clock; busy is never raised.
// Reset clears only the stage valid bits, so no strobe follows reset.
// ----------------------------------------------------------------------------
//
// The conversion is the usual six-sector HSV scheme, done in exact integer
// arithmetic. The hue is folded into one turn, saturation and value are
// clamped to one hundred per cent, and the hue is split into a sector and an
// offset in degrees. With all terms held as numerators over 600000, the
// value, p, q and t terms are formed from two rows of small multipliers, one
// for saturation and one for value. Each channel then takes
// floor(255 * n / 600000), done as a multiply by seventeen, a shift and a
// reciprocal multiply for the division by 625.
//
// Pipeline:
//   stage 1  hue fold, sector split, clamping      (hsv2rgb_decode)
//   stage 2  saturation products                   (hsv2rgb_mix)
//   stage 3  value products                        (hsv2rgb_mix)
//   stage 4  sector routing, times 17, shift       (hsv2rgb_scale)
//   stage 5  reciprocal multiply, result register  (hsv2rgb_scale)
//
// Every stage carries a valid bit alongside its data. Since the receiver
// takes every result in the cycle it appears, no stage ever holds, and a new
// request may be started in every cycle.
module hsv_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hsv2rgb_pkg::req_type req_data,
   output logic                 rsp_strobe,
   output hsv2rgb_pkg::rsp_type rsp_data
);

   hsv2rgb_pkg::dec_stage_type dec_stage;
   hsv2rgb_pkg::num_stage_type num_stage;

   // The pipeline never stalls, so a request is taken whenever start is high.
   assign busy = 1'b0;

   hsv2rgb_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_data   (req_data),
      .out_stage (dec_stage)
   );

   hsv2rgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (dec_stage),
      .out_stage (num_stage)
   );

   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (num_stage),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends hue, saturation and value requests to the converter and checks each
// red, green and blue response against an exact integer colour calculation
// held here, with directed corner requests followed by random streams under
// three sender gap profiles.
// ----------------------------------------------------------------------------
module tb_top;

   import hsv2rgb_pkg::*;

   // Colour terms are numerators over this denominator: 6000 per unit of
   // value, times 100 per cent.
   localparam int unsigned COLOUR_DEN  = 600000;
   localparam int unsigned CHANNEL_MAX = 255;

   // Longest wait for outstanding responses once the last request is taken,
   // and the settling time after that. Both are generous against the depth of
   // the converter's pipeline.
   localparam int DRAIN_LIMIT  = 200;
   localparam int SETTLE_EDGES = 10;

   // Only this many mismatch lines are printed; all of them are counted.
   localparam int REPORT_CAP = 40;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Colours that the converter still owes, oldest first, alongside the
   // requests that produced them for the mismatch messages.
   rsp_type owed_rgb[$];
   req_type owed_hsv[$];

   int colours_sent;
   int colours_checked;
   int mismatch_count;

   hsv_to_rgb_converter uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hard stop well beyond the slowest correct run, which sends 533 requests,
   // some of them with long random gaps.
   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

   // Exact six-sector conversion. The hue is folded into one turn, and
   // saturation and value are clamped to a hundred per cent. The value term
   // and p, q and t are then formed as numerators over COLOUR_DEN, routed to
   // the channels by sector, and each channel is floor(255 * n / COLOUR_DEN).
   // Every product stays within 32 bits.
   function automatic rsp_type rgb_from_hsv(input req_type hsv);
      int unsigned hue, sat, val, sector, offs;
      int unsigned full_n, p_n, q_n, t_n;
      int unsigned r_n, g_n, b_n;
      rsp_type     rgb;
      hue = hsv.hue_deg;
      if (hue >= HUE_TURN) begin
         hue -= HUE_TURN;
      end
      sat = (hsv.sat_pct > PCT_FULL) ? PCT_FULL : hsv.sat_pct;
      val = (hsv.val_pct > PCT_FULL) ? PCT_FULL : hsv.val_pct;
      sector = hue / SECTOR_DEG;
      offs   = hue % SECTOR_DEG;
      full_n = NUM_UNIT * val;
      p_n    = FRAC_FULL * val * (PCT_FULL - sat);
      q_n    = val * (NUM_UNIT - offs * sat);
      t_n    = val * (NUM_UNIT - (FRAC_FULL - offs) * sat);
      case (3'(sector))
         SEC_R_TO_Y: begin r_n = full_n; g_n = t_n;    b_n = p_n;    end
         SEC_Y_TO_G: begin r_n = q_n;    g_n = full_n; b_n = p_n;    end
         SEC_G_TO_C: begin r_n = p_n;    g_n = full_n; b_n = t_n;    end
         SEC_C_TO_B: begin r_n = p_n;    g_n = q_n;    b_n = full_n; end
         SEC_B_TO_M: begin r_n = t_n;    g_n = p_n;    b_n = full_n; end
         // Magenta back to red, the last sector of the turn.
         default: begin r_n = full_n; g_n = p_n;    b_n = q_n;    end
      endcase
      rgb.red   = 8'((CHANNEL_MAX * r_n) / COLOUR_DEN);
      rgb.green = 8'((CHANNEL_MAX * g_n) / COLOUR_DEN);
      rgb.blue  = 8'((CHANNEL_MAX * b_n) / COLOUR_DEN);
      return rgb;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   // Presents one request and holds it until a rising edge takes it, that is
   // an edge at which busy was low. The task is entered and left at a rising
   // edge, so a request that follows at once keeps start high without any
   // second assignment in the same time step.
   task automatic send_request(input req_type hsv);
      start    <= 1'b1;
      req_data <= hsv;
      do @(posedge clock); while (busy !== 1'b0);
      owed_rgb.push_back(rgb_from_hsv(hsv));
      owed_hsv.push_back(hsv);
      colours_sent++;
   endtask

   // Random sender gaps: each cycle the sender stays idle with the given
   // chance, so gaps of every length land against every stage of the
   // pipeline. Junk on the request bus while start is low must be ignored.
   task automatic idle_cycles(input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         start    <= 1'b0;
         req_data <= req_type'($urandom);
         @(posedge clock);
      end
   endtask

   // Both edges of every sector, and the full-turn end of the hue, at full
   // saturation and value, sent back to back.
   task automatic test_sector_boundaries();
      int unsigned edge_hues[12] = '{0, 59, 60, 119, 120, 179,
                                     180, 239, 240, 299, 300, 359};
      foreach (edge_hues[i]) begin
         send_request(req_type'{9'(edge_hues[i]), PCT_FULL, PCT_FULL});
      end
   endtask

   // Hue folding above a full turn, clamping of saturation and value above a
   // hundred per cent, zero value and zero saturation, and all-ones fields.
   task automatic test_range_limits();
      send_request(req_type'{9'd360, 7'd100, 7'd100});
      send_request(req_type'{9'd419, 7'd100, 7'd100});
      send_request(req_type'{9'd511, 7'd127, 7'd127});
      send_request(req_type'{9'd450, 7'd127, 7'd0});
      send_request(req_type'{9'd0,   7'd101, 7'd100});
      send_request(req_type'{9'd90,  7'd100, 7'd101});
      send_request(req_type'{9'd123, 7'd88,  7'd0});
      send_request(req_type'{9'd0,   7'd0,   7'd100});
      send_request(req_type'{9'd200, 7'd0,   7'd57});
      send_request(req_type'{9'd0,   7'd0,   7'd0});
      send_request(req_type'{9'd359, 7'd1,   7'd1});
   endtask

   // Random requests over the full width of every field. Saturation and
   // value land on zero or full somewhat more often than chance gives.
   task automatic test_random_traffic(input int count, input int gap_pct);
      req_type hsv;
      for (int i = 0; i < count; i++) begin
         idle_cycles(gap_pct);
         hsv.hue_deg = 9'($urandom_range(511));
         case ($urandom_range(7))
            0:       hsv.sat_pct = 7'd0;
            1:       hsv.sat_pct = PCT_FULL;
            default: hsv.sat_pct = 7'($urandom_range(127));
         endcase
         case ($urandom_range(7))
            0:       hsv.val_pct = 7'd0;
            1:       hsv.val_pct = PCT_FULL;
            default: hsv.val_pct = 7'($urandom_range(127));
         endcase
         send_request(hsv);
      end
   endtask

   // Lowers start, waits for every owed colour, then lets the pipeline settle
   // so that any stray strobe is still seen.
   task automatic drain_results();
      int waited = 0;
      start <= 1'b0;
      while (owed_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_EDGES) @(posedge clock);
   endtask

   // Every response is taken at the rising edge that ends its strobe cycle.
   // Values are read right after the edge, before the design's own updates
   // of that edge land, so the sample is the one the edge accepts.
   always @(posedge clock) begin : check_colour
      rsp_type want;
      req_type hsv;
      if (reset === 1'b0 && rsp_strobe !== 1'b0) begin
         if (rsp_strobe !== 1'b1) begin
            report_mismatch("response strobe is not a known level");
         end else if (owed_rgb.size() == 0) begin
            report_mismatch($sformatf("unexpected response r=%0d g=%0d b=%0d",
                                      rsp_data.red, rsp_data.green, rsp_data.blue));
         end else begin
            want = owed_rgb.pop_front();
            hsv  = owed_hsv.pop_front();
            colours_checked++;
            if (rsp_data.red !== want.red) begin
               report_mismatch($sformatf("h=%0d s=%0d v=%0d: red %0d, expected %0d",
                  hsv.hue_deg, hsv.sat_pct, hsv.val_pct, rsp_data.red, want.red));
            end
            if (rsp_data.green !== want.green) begin
               report_mismatch($sformatf("h=%0d s=%0d v=%0d: green %0d, expected %0d",
                  hsv.hue_deg, hsv.sat_pct, hsv.val_pct, rsp_data.green, want.green));
            end
            if (rsp_data.blue !== want.blue) begin
               report_mismatch($sformatf("h=%0d s=%0d v=%0d: blue %0d, expected %0d",
                  hsv.hue_deg, hsv.sat_pct, hsv.val_pct, rsp_data.blue, want.blue));
            end
         end
      end
   end

   // Main sequence: reset once, the directed requests back to back, then
   // three random streams. In the first the sender pauses lightly, in the
   // second heavily, and in the last not at all. The receiver cannot hold
   // responses off, so only the sender's pauses vary.
   initial begin
      colours_sent    = 0;
      colours_checked = 0;
      mismatch_count  = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_sector_boundaries();
      test_range_limits();
      test_random_traffic(170, 22);
      test_random_traffic(170, 70);
      test_random_traffic(170, 0);
      drain_results();

      // Anything still owed here never arrived.
      while (owed_rgb.size() != 0) begin
         void'(owed_rgb.pop_front());
         void'(owed_hsv.pop_front());
         report_mismatch("expected response never arrived");
      end

      $display("Converted %0d colours and checked %0d responses, covering every sector",
               colours_sent, colours_checked);
      $display("edge, hue folding, clamping and light, heavy and no sender gaps.");
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_decode.sv
rtl/hsv2rgb_mix.sv
rtl/hsv2rgb_scale.sv
rtl/hsv_to_rgb_converter.sv
test/tb_top.sv
